// File: hw/rtl/spq_pkg.sv
// sorted priority queue: shared types, codes and constants
// used by sorted_priority_queue_core; no dependencies
`default_nettype none

package spq_pkg;

    localparam int SPQ_CAPACITY = 16;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_POP    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_LIST   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_action     action;
        logic [15:0] item_id;
        logic [7:0]  item_priority;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [15:0] out_id;
        logic [7:0]  out_priority;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_DEL_RD,
        S_DEL_CHK,
        S_LST_RD,
        S_LST_OUT
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/sorted_priority_queue_core.sv
// sorted priority queue core: sorted entry memory walked by one compare unit
// depends on spq_pkg
//
// channel   direction  handshake               payload
// request   in         start && !busy          i_request (spq_pkg::t_request)
// result    out        o_valid, one cycle      o_result  (spq_pkg::t_result)
//
// every slot access is a memory read state, then a compare (list: output)
// insert walks from the tail, moving each lower-priority entry down a slot
// pop and remove scan all entries, closing the gap; list returns each entry
// full insert and commands on an empty queue answer next cycle
// reset clears the count and the sequencer; memory contents need no clearing
// busy is high while a request is worked; results cannot be stalled
`default_nettype none

module sorted_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire spq_pkg::t_request i_request,
    output logic                   o_valid,
    output spq_pkg::t_result       o_result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    spq_pkg::t_entry   mem [CAPACITY];
    spq_pkg::t_entry   r_rd_data;

    spq_pkg::t_state   r_state, n_state;
    spq_pkg::t_request r_req;
    spq_pkg::t_entry   r_head, n_head;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_count, n_count;
    logic              r_found, n_found;
    logic              r_valid, n_valid;
    spq_pkg::t_result  r_result, n_result;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    spq_pkg::t_entry   w_wdata;
    logic [AW-1:0]     w_raddr;

    logic              w_accept;
    logic              w_less;
    logic              w_match;
    logic              w_scan_end;
    logic              w_list_last;
    logic [CW-1:0]     w_idx_m1;
    logic [CW-1:0]     w_idx_p1;
    spq_pkg::t_entry   w_new;

    assign w_accept    = start && !busy;
    assign w_less      = r_rd_data.prio < r_req.item_priority;
    assign w_match     = (r_req.action == spq_pkg::ACT_POP) || (r_rd_data.id == r_req.item_id);
    assign w_scan_end  = r_idx == r_count;
    assign w_idx_m1    = r_idx - CW'(1);
    assign w_idx_p1    = r_idx + CW'(1);
    assign w_list_last = w_idx_p1 == r_count;
    assign w_new       = '{id: r_req.item_id, prio: r_req.item_priority};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_request.action == spq_pkg::ACT_INSERT) begin
                        if (r_count < CAP_C) begin
                            n_state = spq_pkg::S_INS_RD;
                        end
                    end else if (r_count != '0) begin
                        if (i_request.action == spq_pkg::ACT_LIST) begin
                            n_state = spq_pkg::S_LST_RD;
                        end else begin
                            n_state = spq_pkg::S_DEL_RD;
                        end
                    end
                end
            end
            spq_pkg::S_INS_RD: begin
                n_state = (r_idx == '0) ? spq_pkg::S_IDLE : spq_pkg::S_INS_CMP;
            end
            spq_pkg::S_INS_CMP: begin
                n_state = w_less ? spq_pkg::S_INS_RD : spq_pkg::S_IDLE;
            end
            spq_pkg::S_DEL_RD: begin
                n_state = w_scan_end ? spq_pkg::S_IDLE : spq_pkg::S_DEL_CHK;
            end
            spq_pkg::S_DEL_CHK: begin
                n_state = spq_pkg::S_DEL_RD;
            end
            spq_pkg::S_LST_RD: begin
                n_state = spq_pkg::S_LST_OUT;
            end
            spq_pkg::S_LST_OUT: begin
                n_state = w_list_last ? spq_pkg::S_IDLE : spq_pkg::S_LST_RD;
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath control and results
    always_comb begin
        n_idx    = r_idx;
        n_count  = r_count;
        n_found  = r_found;
        n_head   = r_head;
        n_valid  = 1'b0;
        n_result = '{status: spq_pkg::ST_OK, out_id: '0, out_priority: '0, last: 1'b1};
        w_we     = 1'b0;
        w_waddr  = r_idx[AW-1:0];
        w_wdata  = w_new;
        w_raddr  = r_idx[AW-1:0];
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_found = 1'b0;
                    if (i_request.action == spq_pkg::ACT_INSERT) begin
                        n_idx = r_count;
                        if (r_count >= CAP_C) begin
                            n_valid         = 1'b1;
                            n_result.status = spq_pkg::ST_FULL;
                        end
                    end else begin
                        n_idx = '0;
                        if (r_count == '0) begin
                            n_valid         = 1'b1;
                            n_result.status = spq_pkg::ST_EMPTY;
                        end
                    end
                end
            end
            spq_pkg::S_INS_RD: begin
                w_raddr = w_idx_m1[AW-1:0];
                if (r_idx == '0) begin
                    w_we    = 1'b1;
                    n_count = r_count + CW'(1);
                    n_valid = 1'b1;
                end
            end
            spq_pkg::S_INS_CMP: begin
                w_we = 1'b1;
                if (w_less) begin
                    w_wdata = r_rd_data;
                    n_idx   = w_idx_m1;
                end else begin
                    n_count = r_count + CW'(1);
                    n_valid = 1'b1;
                end
            end
            spq_pkg::S_DEL_RD: begin
                if (w_scan_end) begin
                    n_valid = 1'b1;
                    if (r_found) begin
                        n_count = r_count - CW'(1);
                        if (r_req.action == spq_pkg::ACT_POP) begin
                            n_result.out_id       = r_head.id;
                            n_result.out_priority = r_head.prio;
                        end
                    end else begin
                        n_result.status = spq_pkg::ST_NOT_FOUND;
                    end
                end
            end
            spq_pkg::S_DEL_CHK: begin
                n_idx = w_idx_p1;
                if (r_found) begin
                    w_we    = 1'b1;
                    w_waddr = w_idx_m1[AW-1:0];
                    w_wdata = r_rd_data;
                end else if (w_match) begin
                    n_found = 1'b1;
                    n_head  = r_rd_data;
                end
            end
            spq_pkg::S_LST_RD: begin
                w_raddr = r_idx[AW-1:0];
            end
            spq_pkg::S_LST_OUT: begin
                n_idx                 = w_idx_p1;
                n_valid               = 1'b1;
                n_result.out_id       = r_rd_data.id;
                n_result.out_priority = r_rd_data.prio;
                n_result.last         = w_list_last;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_found <= n_found;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_request;
        end
        r_head   <= n_head;
        r_result <= n_result;
    end

    assign busy     = r_state != spq_pkg::S_IDLE;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_accept_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_valid || busy))
        else $error("accepted request neither answered nor worked");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_last_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.last == !busy))
        else $error("last flag out of step with busy");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != spq_pkg::ST_OK) |->
            (o_result.out_id == '0 && o_result.out_priority == '0 && o_result.last))
        else $error("error result carries data");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for sorted_priority_queue_core: directed and random requests,
// every result checked against a sorted-array model of the queue kept here
// depends on spq_pkg and sorted_priority_queue_core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 305;
    localparam int CALM_TAIL       = 60;
    localparam int SEGMENT_LEN     = 40;
    localparam int TAIL_CYCLES     = 80;
    localparam int WATCHDOG_LIMIT  = 2000;

    class queue_tracker;
        logic [15:0]      ids [spq_pkg::SPQ_CAPACITY];
        logic [7:0]       prios [spq_pkg::SPQ_CAPACITY];
        int               count;
        spq_pkg::t_result pending[$];
        int               errors;
        int               n_requests;
        int               n_results;
        int               n_full;
        int               n_not_found;
        int               n_list_rows;

        function new();
            count       = 0;
            errors      = 0;
            n_requests  = 0;
            n_results   = 0;
            n_full      = 0;
            n_not_found = 0;
            n_list_rows = 0;
        endfunction

        function void push_result(spq_pkg::t_status st, logic [15:0] id,
                                  logic [7:0] pr, logic lst);
            spq_pkg::t_result r;
            r.status       = st;
            r.out_id       = id;
            r.out_priority = pr;
            r.last         = lst;
            pending.push_back(r);
        endfunction

        function void drop_at(int pos);
            int k;
            for (k = pos; k + 1 < count; k++) begin
                ids[k]   = ids[k + 1];
                prios[k] = prios[k + 1];
            end
            count--;
        endfunction

        function void note_request(spq_pkg::t_request r);
            int pos;
            int k;
            bit found;
            n_requests++;
            if (r.action == spq_pkg::ACT_INSERT) begin
                if (count >= spq_pkg::SPQ_CAPACITY) begin
                    n_full++;
                    push_result(spq_pkg::ST_FULL, '0, '0, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < count && prios[pos] >= r.item_priority)
                        pos++;
                    for (k = count; k > pos; k--) begin
                        ids[k]   = ids[k - 1];
                        prios[k] = prios[k - 1];
                    end
                    ids[pos]   = r.item_id;
                    prios[pos] = r.item_priority;
                    count++;
                    push_result(spq_pkg::ST_OK, '0, '0, 1'b1);
                end
            end else if (count == 0) begin
                push_result(spq_pkg::ST_EMPTY, '0, '0, 1'b1);
            end else if (r.action == spq_pkg::ACT_POP) begin
                push_result(spq_pkg::ST_OK, ids[0], prios[0], 1'b1);
                drop_at(0);
            end else if (r.action == spq_pkg::ACT_REMOVE) begin
                found = 1'b0;
                for (k = 0; k < count && !found; k++) begin
                    if (ids[k] == r.item_id) begin
                        drop_at(k);
                        found = 1'b1;
                    end
                end
                if (found) begin
                    push_result(spq_pkg::ST_OK, '0, '0, 1'b1);
                end else begin
                    n_not_found++;
                    push_result(spq_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                end
            end else begin
                for (k = 0; k < count; k++)
                    push_result(spq_pkg::ST_OK, ids[k], prios[k], k + 1 == count);
                n_list_rows += count;
            end
        endfunction

        function void check_result(spq_pkg::t_result got);
            spq_pkg::t_result want;
            n_results++;
            if (pending.size() == 0) begin
                $error("unexpected result: status %0d id %h priority %h last %b",
                       got.status, got.out_id, got.out_priority, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.out_id !== want.out_id) begin
                $error("out_id: expected %h, got %h", want.out_id, got.out_id);
                errors++;
            end
            if (got.out_priority !== want.out_priority) begin
                $error("out_priority: expected %h, got %h", want.out_priority, got.out_priority);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, got %b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    spq_pkg::t_request i_request;
    logic              o_valid;
    spq_pkg::t_result  o_result;

    queue_tracker tracker = new();
    int           quiet_cycles = 0;

    sorted_priority_queue_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_request(i_request),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                tracker.check_result(o_result);
            if (start && !busy)
                tracker.note_request(i_request);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request or result for %0d cycles", quiet_cycles);
                $display("FAIL sorted_priority_queue_core");
                $finish;
            end
        end
    end

    task automatic send_request(input spq_pkg::t_action act, input logic [15:0] id,
                                input logic [7:0] pr, input bit may_idle);
        spq_pkg::t_request r;
        r.action        = act;
        r.item_id       = id;
        r.item_priority = pr;
        start     <= 1'b1;
        i_request <= r;
        do @(posedge i_clk); while (busy);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [15:0] fill_ids [16] = '{16'h0000, 16'hFFFF, 16'h0042, 16'h0100,
                                       16'h0042, 16'h5A5A, 16'hA5A5, 16'h0001,
                                       16'h8000, 16'h7FFF, 16'h1111, 16'h2222,
                                       16'h3333, 16'h4444, 16'h5555, 16'h6666};
        logic [7:0]  fill_prios [16] = '{8'h00, 8'hFF, 8'h80, 8'h80,
                                         8'h10, 8'hFF, 8'h01, 8'h7F,
                                         8'h80, 8'hFE, 8'h00, 8'h55,
                                         8'hAA, 8'h80, 8'h02, 8'hFF};
        logic [15:0] id_pool [8] = '{16'h0001, 16'h00FF, 16'hFF00, 16'h8000,
                                     16'h7FFF, 16'h1234, 16'hABCD, 16'h0000};
        logic [7:0]  prio_pool [4] = '{8'h00, 8'h40, 8'h80, 8'hFF};
        spq_pkg::t_action act;
        logic [15:0]      id;
        logic [7:0]       pr;
        int               roll;
        bit               filling;
        bit               may_idle;

        start     = 1'b0;
        i_request = '0;
        i_rst_n   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue
        send_request(spq_pkg::ACT_POP, 16'h0000, 8'h00, 1'b1);
        send_request(spq_pkg::ACT_REMOVE, 16'hFFFF, 8'hFF, 1'b1);
        send_request(spq_pkg::ACT_LIST, 16'h0000, 8'h00, 1'b1);
        // fill with ties and a repeated id, then overflow
        for (int n = 0; n < 16; n++)
            send_request(spq_pkg::ACT_INSERT, fill_ids[n], fill_prios[n], 1'b1);
        send_request(spq_pkg::ACT_INSERT, 16'hBEEF, 8'hC3, 1'b1);
        send_request(spq_pkg::ACT_LIST, 16'h0000, 8'h00, 1'b1);
        send_request(spq_pkg::ACT_REMOVE, 16'h9999, 8'h00, 1'b1);
        send_request(spq_pkg::ACT_REMOVE, 16'h0042, 8'h00, 1'b1);
        send_request(spq_pkg::ACT_POP, 16'h0000, 8'h00, 1'b1);
        send_request(spq_pkg::ACT_LIST, 16'h0000, 8'h00, 1'b1);

        // alternating fill-heavy and drain-heavy segments
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            filling = ((n / SEGMENT_LEN) % 2) == 0;
            roll    = $urandom_range(0, 99);
            if (roll < (filling ? 55 : 25))
                act = spq_pkg::ACT_INSERT;
            else if (roll < (filling ? 70 : 55))
                act = spq_pkg::ACT_POP;
            else if (roll < (filling ? 88 : 85))
                act = spq_pkg::ACT_REMOVE;
            else
                act = spq_pkg::ACT_LIST;
            if ($urandom_range(0, 4) != 0)
                id = id_pool[$urandom_range(0, 7)];
            else
                id = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 1) == 0)
                pr = prio_pool[$urandom_range(0, 3)];
            else
                pr = 8'($urandom_range(0, 255));
            may_idle = n < RANDOM_REQUESTS - CALM_TAIL;
            send_request(act, id, pr, may_idle);
        end
        start <= 1'b0;

        while (tracker.pending.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.pending.size() != 0) begin
            $error("%0d expected results never arrived", tracker.pending.size());
            tracker.errors++;
        end

        $display("covered %0d requests and %0d results: %0d list rows, %0d full refusals,",
                 tracker.n_requests, tracker.n_results, tracker.n_list_rows, tracker.n_full);
        $display("%0d id misses, %0d mismatches", tracker.n_not_found, tracker.errors);
        if (tracker.errors == 0)
            $display("PASS sorted_priority_queue_core");
        else
            $display("FAIL sorted_priority_queue_core");
        $finish;
    end

endmodule
